// File: design/tkd_pkg.sv
// tkd_pkg: shared types, constants and widths for the touch keypad decoder.
// No dependencies; used by tkd_div, tkd_keyhit and the top through scoped names.
package tkd_pkg;

	localparam int RAW_W   = 12;
	localparam int TIME_W  = 32;
	localparam int MS_W    = 16;
	localparam int XPOS_W  = 9;
	localparam int YPOS_W  = 8;
	localparam int KEY_W_B = 4;
	localparam int QUO_W   = XPOS_W;
	localparam int NUM_W   = RAW_W + QUO_W;
	localparam int CNT_W   = $clog2(QUO_W + 1);
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;

	// Screen and keypad geometry
	localparam int SCREEN_W    = 320;
	localparam int SCREEN_H    = 240;
	localparam int KEY_COLUMNS = 3;
	localparam int KEY_ROWS    = 4;
	localparam int KEY_WIDTH   = 96;
	localparam int KEY_HEIGHT  = 34;
	localparam int KEY_GAP_X   = 8;
	localparam int KEY_GAP_Y   = 2;
	localparam int KEY_LEFT    = 8;
	localparam int KEY_TOP     = 88;
	localparam int PITCH_X     = KEY_WIDTH + KEY_GAP_X;
	localparam int PITCH_Y     = KEY_HEIGHT + KEY_GAP_Y;

	localparam logic [XPOS_W-1:0] X_LAST = XPOS_W'(SCREEN_W - 1);
	localparam logic [XPOS_W-1:0] Y_LAST = XPOS_W'(SCREEN_H - 1);

	// Register reset values
	localparam logic [RAW_W-1:0] RAW_MAX_RST  = RAW_W'(4095);
	localparam logic [MS_W-1:0]  LOCKOUT_RST  = MS_W'(220);
	localparam logic [MS_W-1:0]  HILITE_RST   = MS_W'(180);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_X_MIN   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_X_MAX   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_Y_MIN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Y_MAX   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SWAP    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_HILITE  = 3'd6;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAP_X,
		ST_DIV_X,
		ST_MAP_Y,
		ST_DIV_Y,
		ST_HIT,
		ST_EXPIRE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [RAW_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic [QUO_W-1:0] quot;
	} div_rsp_t;

endpackage

// File: design/tkd_div.sv
// tkd_div: restoring divider, one quotient bit per cycle, shared by both axes.
// Depends on tkd_pkg. Caller guarantees num < den * 2^QUO_W.
module tkd_div (
	input  logic              clk,
	input  logic              arst_n,
	input  tkd_pkg::div_req_t req,
	output tkd_pkg::div_rsp_t rsp
);

	logic [tkd_pkg::RAW_W-1:0] rem_q;
	logic [tkd_pkg::RAW_W-1:0] den_q;
	logic [tkd_pkg::QUO_W-1:0] sh_q;
	logic [tkd_pkg::CNT_W-1:0] cnt_q;
	logic                      busy_q;

	logic [tkd_pkg::RAW_W:0]   part;
	logic [tkd_pkg::RAW_W:0]   diff;
	logic                      ge;

	assign part = {rem_q, sh_q[tkd_pkg::QUO_W-1]};
	assign ge   = part >= {1'b0, den_q};
	assign diff = part - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= tkd_pkg::CNT_W'(tkd_pkg::QUO_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - tkd_pkg::CNT_W'(1);
			if (cnt_q == tkd_pkg::CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num[tkd_pkg::NUM_W-1:tkd_pkg::QUO_W];
			sh_q  <= req.num[tkd_pkg::QUO_W-1:0];
			den_q <= req.den;
		end else if (busy_q) begin
			// partial remainder stays below den, so RAW_W bits hold it
			rem_q <= ge ? diff[tkd_pkg::RAW_W-1:0] : part[tkd_pkg::RAW_W-1:0];
			sh_q  <= {sh_q[tkd_pkg::QUO_W-2:0], ge};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.quot = sh_q;

endmodule

// File: design/tkd_keyhit.sv
// tkd_keyhit: hit test of a screen point against the keypad grid, inclusive edges.
// Depends on tkd_pkg. Keys do not overlap; the first match in row-major order wins.
module tkd_keyhit (
	input  logic [tkd_pkg::XPOS_W-1:0]  x,
	input  logic [tkd_pkg::YPOS_W-1:0]  y,
	output logic                        hit,
	output logic [tkd_pkg::KEY_W_B-1:0] key
);

	always_comb begin
		int bx;
		int by;
		int xi;
		int yi;
		hit = 1'b0;
		key = '0;
		xi  = int'(x);
		yi  = int'(y);
		for (int r = 0; r < tkd_pkg::KEY_ROWS; r++) begin
			for (int c = 0; c < tkd_pkg::KEY_COLUMNS; c++) begin
				bx = tkd_pkg::KEY_LEFT + c * tkd_pkg::PITCH_X;
				by = tkd_pkg::KEY_TOP + r * tkd_pkg::PITCH_Y;
				if (!hit && xi >= bx && xi <= bx + tkd_pkg::KEY_WIDTH &&
				    yi >= by && yi <= by + tkd_pkg::KEY_HEIGHT) begin
					hit = 1'b1;
					key = tkd_pkg::KEY_W_B'(r * tkd_pkg::KEY_COLUMNS + c);
				end
			end
		end
	end

endmodule

// File: design/touch_keypad_decoder_top.sv
// touch_keypad_decoder_top: calibration, screen mapping, keypad hit test, press lockout
// and highlight timing. Depends on tkd_pkg, tkd_div and tkd_keyhit.
//
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+------------------------------------------
// sample   | in        | s_tvalid/s_tready  | s_tuser: touched; s_tdata: raw_x, raw_y, now_ms
// result   | out       | m_tvalid/m_tready  | m_tuser: map_valid; m_tdata: see port list
// config   | in        | cfg_valid/cfg_ready| cfg_index, cfg_data (always ready)
//
// A touched sample under a valid calibration makes two 9-step passes through the
// shared serial divider, one per axis; an untouched sample or an invalid calibration
// makes none. An axis whose raw reading lies below its min, or at or above its max,
// skips its division.
// s_tready is high only while the sequencer is idle; a finished result sits in the
// output register, so a new sample is taken while the last result waits.
// Reset clears calibration to its defaults and all press and highlight state.
module touch_keypad_decoder_top (
	input  logic                            clk,
	input  logic                            arst_n,
	// sample channel
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [55:0]                     s_tdata,  // raw_x[11:0], raw_y[23:12], now_ms[55:24]
	input  logic                            s_tuser,  // touched
	// result channel
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// mapped_x[8:0], mapped_y[16:9], press_accepted[17], pressed_key[21:18],
	// press_total[53:22], highlight_valid[54], highlight_key[58:55], zero[63:59]
	output logic [63:0]                     m_tdata,
	output logic                            m_tuser,  // map_valid
	// configuration write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tkd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tkd_pkg::CFG_DAT_W-1:0]   cfg_data
);

	// ---------------- configuration registers ----------------
	logic [tkd_pkg::RAW_W-1:0] x_min_q, x_max_q, y_min_q, y_max_q;
	logic                      swap_q;
	logic [tkd_pkg::MS_W-1:0]  lockout_q, hilite_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_min_q   <= '0;
			x_max_q   <= tkd_pkg::RAW_MAX_RST;
			y_min_q   <= '0;
			y_max_q   <= tkd_pkg::RAW_MAX_RST;
			swap_q    <= 1'b0;
			lockout_q <= tkd_pkg::LOCKOUT_RST;
			hilite_q  <= tkd_pkg::HILITE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tkd_pkg::REG_X_MIN:   x_min_q   <= cfg_data[tkd_pkg::RAW_W-1:0];
				tkd_pkg::REG_X_MAX:   x_max_q   <= cfg_data[tkd_pkg::RAW_W-1:0];
				tkd_pkg::REG_Y_MIN:   y_min_q   <= cfg_data[tkd_pkg::RAW_W-1:0];
				tkd_pkg::REG_Y_MAX:   y_max_q   <= cfg_data[tkd_pkg::RAW_W-1:0];
				tkd_pkg::REG_SWAP:    swap_q    <= cfg_data[0];
				tkd_pkg::REG_LOCKOUT: lockout_q <= cfg_data;
				tkd_pkg::REG_HILITE:  hilite_q  <= cfg_data;
				default: ;  // writes past the register list are dropped
			endcase
		end
	end

	logic cal_ok;
	assign cal_ok = (x_max_q > x_min_q) && (y_max_q > y_min_q);

	// ---------------- sequencer ----------------
	tkd_pkg::state_t state_q, state_nx;
	tkd_pkg::div_req_t div_req;
	tkd_pkg::div_rsp_t div_rsp;

	logic in_xfer, out_free, out_load;
	logic [tkd_pkg::RAW_W-1:0]  raw_x_q, raw_y_q;
	logic [tkd_pkg::TIME_W-1:0] now_q;

	// per-axis operand selection for the shared divider
	logic                       axis_y;
	logic [tkd_pkg::RAW_W-1:0]  ax_raw, ax_lo, ax_hi;
	logic [tkd_pkg::QUO_W-1:0]  ax_last;
	logic                       ax_below, ax_above;
	logic [tkd_pkg::RAW_W-1:0]  ax_off, ax_den;
	logic [tkd_pkg::NUM_W-1:0]  ax_num;

	assign axis_y   = (state_q == tkd_pkg::ST_MAP_Y);
	assign ax_raw   = (swap_q ^ axis_y) ? raw_y_q : raw_x_q;
	assign ax_lo    = axis_y ? y_min_q : x_min_q;
	assign ax_hi    = axis_y ? y_max_q : x_max_q;
	assign ax_last  = axis_y ? tkd_pkg::Y_LAST : tkd_pkg::X_LAST;
	assign ax_below = ax_raw < ax_lo;   // truncates to zero or goes negative: clamp low
	assign ax_above = ax_raw >= ax_hi;  // quotient reaches the last pixel: clamp high
	assign ax_off   = ax_raw - ax_lo;
	assign ax_den   = ax_hi - ax_lo;
	assign ax_num   = tkd_pkg::NUM_W'(ax_off) * tkd_pkg::NUM_W'(ax_last);

	logic ax_direct;
	assign ax_direct = ax_below || ax_above;

	assign in_xfer  = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			tkd_pkg::ST_IDLE:
				if (in_xfer) begin
					state_nx = (s_tuser && cal_ok) ? tkd_pkg::ST_MAP_X : tkd_pkg::ST_EXPIRE;
				end
			tkd_pkg::ST_MAP_X:
				state_nx = ax_direct ? tkd_pkg::ST_MAP_Y : tkd_pkg::ST_DIV_X;
			tkd_pkg::ST_DIV_X:
				if (!div_rsp.busy) begin
					state_nx = tkd_pkg::ST_MAP_Y;
				end
			tkd_pkg::ST_MAP_Y:
				state_nx = ax_direct ? tkd_pkg::ST_HIT : tkd_pkg::ST_DIV_Y;
			tkd_pkg::ST_DIV_Y:
				if (!div_rsp.busy) begin
					state_nx = tkd_pkg::ST_HIT;
				end
			tkd_pkg::ST_HIT:
				state_nx = tkd_pkg::ST_EXPIRE;
			tkd_pkg::ST_EXPIRE:
				state_nx = tkd_pkg::ST_DONE;
			tkd_pkg::ST_DONE:
				if (out_free) begin
					state_nx = tkd_pkg::ST_IDLE;
				end
			default:
				state_nx = tkd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready      = (state_q == tkd_pkg::ST_IDLE);
		div_req.start = ((state_q == tkd_pkg::ST_MAP_X) || (state_q == tkd_pkg::ST_MAP_Y)) &&
		                !ax_direct;
		div_req.num   = ax_num;
		div_req.den   = ax_den;
		out_load      = (state_q == tkd_pkg::ST_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tkd_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	tkd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// ---------------- sample and mapping registers ----------------
	logic                       map_valid_q;
	logic [tkd_pkg::XPOS_W-1:0] mx_q;
	logic [tkd_pkg::YPOS_W-1:0] my_q;
	logic [tkd_pkg::QUO_W-1:0]  ax_direct_val;

	assign ax_direct_val = ax_below ? '0 : ax_last;

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			raw_x_q     <= s_tdata[11:0];
			raw_y_q     <= s_tdata[23:12];
			now_q       <= s_tdata[55:24];
			map_valid_q <= s_tuser && cal_ok;
			mx_q        <= '0;
			my_q        <= '0;
		end else begin
			case (state_q)
				tkd_pkg::ST_MAP_X:
					if (ax_direct) begin
						mx_q <= ax_direct_val;
					end
				tkd_pkg::ST_DIV_X:
					if (!div_rsp.busy) begin
						mx_q <= div_rsp.quot;
					end
				tkd_pkg::ST_MAP_Y:
					if (ax_direct) begin
						my_q <= ax_direct_val[tkd_pkg::YPOS_W-1:0];
					end
				tkd_pkg::ST_DIV_Y:
					if (!div_rsp.busy) begin
						my_q <= div_rsp.quot[tkd_pkg::YPOS_W-1:0];
					end
				default: ;
			endcase
		end
	end

	// ---------------- hit test, lockout and highlight ----------------
	logic                        key_hit;
	logic [tkd_pkg::KEY_W_B-1:0] key_idx;

	tkd_keyhit u_keyhit (
		.x   (mx_q),
		.y   (my_q),
		.hit (key_hit),
		.key (key_idx)
	);

	logic [tkd_pkg::TIME_W-1:0]  last_press_q, press_cnt_q, lit_until_q;
	logic                        lit_valid_q;
	logic [tkd_pkg::KEY_W_B-1:0] lit_key_q;
	logic                        acc_q;
	logic [tkd_pkg::KEY_W_B-1:0] pkey_q;
	logic [tkd_pkg::TIME_W-1:0]  elapsed;
	logic                        press_now;

	// wrapping elapsed time against the lockout
	assign elapsed   = now_q - last_press_q;
	assign press_now = (state_q == tkd_pkg::ST_HIT) && map_valid_q && key_hit &&
	                   (elapsed > tkd_pkg::TIME_W'(lockout_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_press_q <= '0;
			press_cnt_q  <= '0;
			lit_valid_q  <= 1'b0;
			lit_key_q    <= '0;
			lit_until_q  <= '0;
			acc_q        <= 1'b0;
			pkey_q       <= '0;
		end else if (in_xfer) begin
			acc_q  <= 1'b0;
			pkey_q <= '0;
		end else if (press_now) begin
			acc_q        <= 1'b1;
			pkey_q       <= key_idx;
			last_press_q <= now_q;
			press_cnt_q  <= press_cnt_q + tkd_pkg::TIME_W'(1);
			lit_valid_q  <= 1'b1;
			lit_key_q    <= key_idx;
			lit_until_q  <= now_q + tkd_pkg::TIME_W'(hilite_q);
		end else if ((state_q == tkd_pkg::ST_EXPIRE) && lit_valid_q &&
		             (now_q >= lit_until_q)) begin
			// plain compare: an end time that wrapped expires at once
			lit_valid_q <= 1'b0;
			lit_key_q   <= '0;
		end
	end

	// ---------------- output register ----------------
	logic        m_tvalid_q;
	logic        m_tuser_q;
	logic [63:0] m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tuser_q <= map_valid_q;
			m_tdata_q <= {5'd0,
			              lit_valid_q ? lit_key_q : 4'd0,
			              lit_valid_q,
			              press_cnt_q,
			              pkey_q,
			              acc_q,
			              my_q,
			              mx_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_tuser_q;
	assign m_tdata  = m_tdata_q;

endmodule

// File: design/tkd_chk.sv
// tkd_chk: port-level checks on the touch keypad decoder's result and sample channels.
// Depends on touch_keypad_decoder_top; attached to it by the bind at the foot of this file.
module tkd_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic        m_tuser
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// mapped point lies on the screen
	a_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[8:0] <= 9'd319) && (m_tdata[16:9] <= 8'd239))
		else $error("mapped point off screen");

	// no mapping means zero coordinates and no press
	a_unmapped: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> (m_tdata[16:0] == 17'd0) && !m_tdata[17] &&
		(m_tdata[21:18] == 4'd0))
		else $error("unmapped sample carries coordinates or a press");

	// a press names a real key
	a_press_key: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[17] |-> (m_tdata[21:18] <= 4'd11))
		else $error("press on a key index past the keypad");

	// the sequencer is busy in the cycle after taking a sample
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("sample taken while previous one in flight");

endmodule

bind touch_keypad_decoder_top tkd_chk u_tkd_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
